/* design/tcm_pkg.sv */
// Shared types, register map and constants of the three-resource credit meter.
package tcm_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned ProdW = 2 * DataW;
  localparam int unsigned HalfW = DataW / 2;
  localparam int unsigned AddrW = 6;
  localparam int unsigned CntW  = 6;

  localparam logic [DataW-1:0] AllOnes = '1;

  // Four partial products, then the last one is accumulated.
  localparam logic [CntW-1:0] MulLast = CntW'(4);
  localparam logic [CntW-1:0] DivLast = CntW'(DataW - 1);

  typedef enum logic [1:0] {
    MODE_DISK = 2'd0,
    MODE_NET  = 2'd1,
    MODE_COMP = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_LIMIT     = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_NO_CREDIT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    REG_DISK_LIMIT = 3'd0,
    REG_NET_LIMIT  = 3'd1,
    REG_COMP_LIMIT = 3'd2,
    REG_DISK_COST  = 3'd3,
    REG_NET_COST   = 3'd4,
    REG_COMP_COST  = 3'd5,
    REG_SESS_CRED  = 3'd6,
    REG_SESS_EN    = 3'd7
  } reg_e;

  typedef struct packed {
    logic       load;
    logic       mul;
    logic [1:0] mul_idx;
    logic       acc;
    logic       check;
    logic       update;
    logic       result;
    logic       div;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
  } stat_t;

endpackage

/* design/tcm_ifs.sv */
// Valid/ready channel interfaces for the metering requests and their results.
interface tcm_item_if import tcm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       mode;
  logic [DataW-1:0] amount;

  modport source (output valid, output mode, output amount, input ready);
  modport sink (input valid, input mode, input amount, output ready);
endinterface

interface tcm_result_if import tcm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [DataW-1:0] budget_left;
  logic [DataW-1:0] budget_used;
  logic [DataW-1:0] credit_left;
  logic [DataW-1:0] credit_used;
  logic [DataW-1:0] units_affordable;

  modport source (output valid, output status, output budget_left, output budget_used,
                  output credit_left, output credit_used, output units_affordable,
                  input ready);
  modport sink (input valid, input status, input budget_left, input budget_used,
                input credit_left, input credit_used, input units_affordable,
                output ready);
endinterface

/* design/tcm_ctrl.sv */
// Sequencing state machine of the credit meter.
module tcm_ctrl import tcm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CHECK,
    S_UPDATE,
    S_RESULT,
    S_DIV,
    S_EMIT
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic            out_valid_q;
  logic            out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.mul     = (state_q == S_MUL) && (cnt_q < MulLast);
    cmd_o.mul_idx = cnt_q[1:0];
    cmd_o.acc     = (state_q == S_MUL) && (cnt_q != '0);
    cmd_o.check   = (state_q == S_CHECK);
    cmd_o.update  = (state_q == S_UPDATE);
    cmd_o.result  = (state_q == S_RESULT);
    cmd_o.div     = (state_q == S_DIV);
    cmd_o.emit    = (state_q == S_EMIT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // A new result may replace the one leaving in the same cycle.
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_MUL;
            cnt_q   <= '0;
          end
        end
        S_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == MulLast) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK:  state_q <= S_UPDATE;
        S_UPDATE: state_q <= S_RESULT;
        S_RESULT: begin
          cnt_q   <= '0;
          state_q <= stat_i.need_div ? S_DIV : S_EMIT;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DivLast) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/tcm_dp.sv */
// Datapath of the credit meter: registers, budgets, serial multiplier and divider.
module tcm_dp import tcm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output stat_t            stat_o,
  input  logic             cfg_we_i,
  input  reg_e             cfg_idx_i,
  input  logic [DataW-1:0] cfg_wdata_i,
  output logic [DataW-1:0] cfg_rdata_o,
  input  logic [1:0]       mode_i,
  input  logic [DataW-1:0] amount_i,
  output logic [1:0]       status_o,
  output logic [DataW-1:0] budget_left_o,
  output logic [DataW-1:0] budget_used_o,
  output logic [DataW-1:0] credit_left_o,
  output logic [DataW-1:0] credit_used_o,
  output logic [DataW-1:0] units_affordable_o
);

  // Architectural state and configuration.
  logic [DataW-1:0] lim_q  [3];
  logic [DataW-1:0] left_q [3];
  logic [DataW-1:0] cost_q [3];
  logic [DataW-1:0] sc_q;
  logic [DataW-1:0] pool_q;
  logic             en_q;

  // Per-item working registers.
  mode_e            mode_q;
  logic [DataW-1:0] amount_q;
  logic [DataW-1:0] prod_q;
  logic [1:0]       prod_sh_q;
  logic [ProdW-1:0] acc_q;
  status_e          status_q;
  logic [DataW-1:0] bl_q;
  logic [DataW-1:0] bu_q;
  logic [DataW-1:0] cl_q;
  logic [DataW-1:0] cu_q;
  logic [DataW-1:0] rem_q;
  logic [DataW-1:0] quo_q;

  // Output register.
  status_e          out_status_q;
  logic [DataW-1:0] out_bl_q;
  logic [DataW-1:0] out_bu_q;
  logic [DataW-1:0] out_cl_q;
  logic [DataW-1:0] out_cu_q;
  logic [DataW-1:0] out_ua_q;

  logic             sel_valid;
  logic [DataW-1:0] sel_lim;
  logic [DataW-1:0] sel_left;
  logic [DataW-1:0] sel_cost;
  status_e          chk_status;
  logic [HalfW-1:0] a_half;
  logic [HalfW-1:0] c_half;
  logic [DataW:0]   rem_sh;
  logic [DataW:0]   diff;
  logic [DataW-1:0] ua;

  always_comb begin
    sel_valid = 1'b1;
    sel_lim   = '0;
    sel_left  = '0;
    sel_cost  = '0;
    case (mode_q)
      MODE_DISK: begin
        sel_lim  = lim_q[0];
        sel_left = left_q[0];
        sel_cost = cost_q[0];
      end
      MODE_NET: begin
        sel_lim  = lim_q[1];
        sel_left = left_q[1];
        sel_cost = cost_q[1];
      end
      MODE_COMP: begin
        sel_lim  = lim_q[2];
        sel_left = left_q[2];
        sel_cost = cost_q[2];
      end
      default: sel_valid = 1'b0;
    endcase
  end

  assign stat_o.need_div = sel_valid && en_q && (sel_cost != '0);

  always_comb begin
    case (cfg_idx_i)
      REG_DISK_LIMIT: cfg_rdata_o = lim_q[0];
      REG_NET_LIMIT:  cfg_rdata_o = lim_q[1];
      REG_COMP_LIMIT: cfg_rdata_o = lim_q[2];
      REG_DISK_COST:  cfg_rdata_o = cost_q[0];
      REG_NET_COST:   cfg_rdata_o = cost_q[1];
      REG_COMP_COST:  cfg_rdata_o = cost_q[2];
      REG_SESS_CRED:  cfg_rdata_o = sc_q;
      REG_SESS_EN:    cfg_rdata_o = {{(DataW-1){1'b0}}, en_q};
      default:        cfg_rdata_o = '0;
    endcase
  end

  // The checks run in priority order: budget, product overflow, pool.
  always_comb begin
    if (!sel_valid) begin
      chk_status = ST_OK;
    end else if (amount_q > sel_left) begin
      chk_status = ST_LIMIT;
    end else if (en_q && (acc_q[ProdW-1:DataW] != '0)) begin
      chk_status = ST_OVERFLOW;
    end else if (en_q && (acc_q[DataW-1:0] > pool_q)) begin
      chk_status = ST_NO_CREDIT;
    end else begin
      chk_status = ST_OK;
    end
  end

  assign a_half = cmd_i.mul_idx[0] ? amount_q[DataW-1:HalfW] : amount_q[HalfW-1:0];
  assign c_half = cmd_i.mul_idx[1] ? sel_cost[DataW-1:HalfW] : sel_cost[HalfW-1:0];

  // One restoring division step: the partial remainder stays below the cost.
  assign rem_sh = {rem_q, quo_q[DataW-1]};
  assign diff   = rem_sh - {1'b0, sel_cost};

  always_comb begin
    if (!sel_valid) begin
      ua = '0;
    end else if (en_q) begin
      ua = (sel_cost == '0) ? AllOnes : quo_q;
    end else begin
      ua = bl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        lim_q[i]  <= AllOnes;
        left_q[i] <= AllOnes;
        cost_q[i] <= '0;
      end
      sc_q   <= '0;
      pool_q <= '0;
      en_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DISK_LIMIT: begin
          lim_q[0]  <= cfg_wdata_i;
          left_q[0] <= cfg_wdata_i;
        end
        REG_NET_LIMIT: begin
          lim_q[1]  <= cfg_wdata_i;
          left_q[1] <= cfg_wdata_i;
        end
        REG_COMP_LIMIT: begin
          lim_q[2]  <= cfg_wdata_i;
          left_q[2] <= cfg_wdata_i;
        end
        REG_DISK_COST: cost_q[0] <= cfg_wdata_i;
        REG_NET_COST:  cost_q[1] <= cfg_wdata_i;
        REG_COMP_COST: cost_q[2] <= cfg_wdata_i;
        REG_SESS_CRED: begin
          sc_q   <= cfg_wdata_i;
          pool_q <= cfg_wdata_i;
        end
        REG_SESS_EN: en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end else if (cmd_i.update && sel_valid && (status_q == ST_OK)) begin
      if (en_q) begin
        pool_q <= pool_q - acc_q[DataW-1:0];
      end
      case (mode_q)
        MODE_DISK: left_q[0] <= left_q[0] - amount_q;
        MODE_NET:  left_q[1] <= left_q[1] - amount_q;
        MODE_COMP: left_q[2] <= left_q[2] - amount_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q   <= mode_e'(mode_i);
      amount_q <= amount_i;
      acc_q    <= '0;
    end
    if (cmd_i.mul) begin
      prod_q    <= a_half * c_half;
      prod_sh_q <= {1'b0, cmd_i.mul_idx[0]} + {1'b0, cmd_i.mul_idx[1]};
    end
    if (cmd_i.acc) begin
      acc_q <= acc_q + ({{DataW{1'b0}}, prod_q} << {prod_sh_q, 5'd0});
    end
    if (cmd_i.check) begin
      status_q <= chk_status;
    end
    if (cmd_i.result) begin
      bl_q  <= sel_valid ? sel_left : '0;
      bu_q  <= sel_valid ? (sel_lim - sel_left) : '0;
      cl_q  <= pool_q;
      cu_q  <= sc_q - pool_q;
      rem_q <= '0;
      quo_q <= pool_q;
    end
    if (cmd_i.div) begin
      if (!diff[DataW]) begin
        rem_q <= diff[DataW-1:0];
        quo_q <= {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DataW-1:0];
        quo_q <= {quo_q[DataW-2:0], 1'b0};
      end
    end
    if (cmd_i.emit) begin
      out_status_q <= status_q;
      out_bl_q     <= bl_q;
      out_bu_q     <= bu_q;
      out_cl_q     <= cl_q;
      out_cu_q     <= cu_q;
      out_ua_q     <= ua;
    end
  end

  assign status_o           = out_status_q;
  assign budget_left_o      = out_bl_q;
  assign budget_used_o      = out_bu_q;
  assign credit_left_o      = out_cl_q;
  assign credit_used_o      = out_cu_q;
  assign units_affordable_o = out_ua_q;

endmodule

/* design/three_resource_credit_meter.sv */
// Three-resource credit meter: the top level joining controller, datapath and ports.
//
// Requests arrive on item_i (a resource code and an amount) and each produces
// exactly one transfer on result_o carrying the status, the budget's remaining
// and used figures, the credit pool's remaining and used figures and the
// number of units still affordable. Budgets, costs and the session credit are
// programmed through the APB-style port, one 64-bit register every 8 bytes;
// they may only be written while no request is in flight.
// A request passes through the serial 32x32 multiplier that forms amount times
// cost, then the check, update and result steps, then the one-bit-per-cycle
// restoring divider when a session is active with a non-zero cost, and last
// the output register is loaded. The controller then returns to idle, and
// only there does it take the next request.
// The result sits in an output register, so a further request may be accepted
// while the receiver stalls; that request then waits in its final step until
// the output register has been freed by the transfer.
// Reset loads every limit and remaining budget with all-ones, clears the
// costs, the session credit, the pool and the session enable, and leaves the
// block idle with no result pending.
module three_resource_credit_meter import tcm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  tcm_item_if.sink          item_i,
  tcm_result_if.source      result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  cmd_t  cmd;
  stat_t stat;
  logic  cfg_we;
  reg_e  cfg_idx;

  // The port never inserts wait states; a write lands in the access phase.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_e'(paddr[AddrW-1:3]);

  // The controller steps through multiply, check, update, result, divide and emit, and
  // owns both handshakes; the datapath only follows its commands.
  tcm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tcm_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (pwdata),
    .cfg_rdata_o        (prdata),
    .mode_i             (item_i.mode),
    .amount_i           (item_i.amount),
    .status_o           (result_o.status),
    .budget_left_o      (result_o.budget_left),
    .budget_used_o      (result_o.budget_used),
    .credit_left_o      (result_o.credit_left),
    .credit_used_o      (result_o.credit_used),
    .units_affordable_o (result_o.units_affordable)
  );

endmodule

/* tb/sv/tcm_meter_checker.sv */
`timescale 1ns / 100ps
// Scoreboard of the credit meter: tracks the register port, predicts each result and compares it.
module tcm_meter_checker import tcm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  tcm_item_if              item_mon,
  tcm_result_if            result_mon,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic [AddrW-1:0] paddr_i,
  input  logic [DataW-1:0] pwdata_i,
  input  logic             pready_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o,
  output int unsigned      results_seen_o
);

  typedef struct packed {
    status_e          status;
    logic [DataW-1:0] budget_left;
    logic [DataW-1:0] budget_used;
    logic [DataW-1:0] credit_left;
    logic [DataW-1:0] credit_used;
    logic [DataW-1:0] units_affordable;
  } meter_result_t;

  // Shadow of the programmed registers and of the running budgets.
  logic [DataW-1:0] limit_q [3];
  logic [DataW-1:0] cost_q  [3];
  logic [DataW-1:0] left_q  [3];
  logic [DataW-1:0] sess_credit_q;
  logic [DataW-1:0] pool_q;
  logic             sess_en_q;

  meter_result_t    expected_q [$];
  int unsigned      fail_cnt;
  int unsigned      seen_cnt;

  task automatic meter_reset();
    for (int i = 0; i < 3; i++) begin
      limit_q[i] = AllOnes;
      cost_q[i]  = '0;
      left_q[i]  = AllOnes;
    end
    sess_credit_q = '0;
    pool_q        = '0;
    sess_en_q     = 1'b0;
  endtask

  task automatic apply_reg(input reg_e idx, input logic [DataW-1:0] val);
    case (idx)
      REG_DISK_LIMIT: begin
        limit_q[0] = val;
        left_q[0]  = val;
      end
      REG_NET_LIMIT: begin
        limit_q[1] = val;
        left_q[1]  = val;
      end
      REG_COMP_LIMIT: begin
        limit_q[2] = val;
        left_q[2]  = val;
      end
      REG_DISK_COST: cost_q[0] = val;
      REG_NET_COST:  cost_q[1] = val;
      REG_COMP_COST: cost_q[2] = val;
      REG_SESS_CRED: begin
        sess_credit_q = val;
        pool_q        = val;
      end
      REG_SESS_EN:   sess_en_q = val[0];
      default: ;
    endcase
  endtask

  // Charges one request against its budget and the pool, returning what the block should report.
  function automatic meter_result_t meter_charge(input mode_e m, input logic [DataW-1:0] amt);
    meter_result_t    r;
    logic [ProdW-1:0] charge;
    logic [DataW-1:0] c;
    int               idx;
    r        = '0;
    r.status = ST_OK;
    if (m != MODE_NONE) begin
      idx    = int'(m);
      c      = cost_q[idx];
      charge = {{DataW{1'b0}}, amt} * {{DataW{1'b0}}, c};
      if (amt > left_q[idx]) begin
        r.status = ST_LIMIT;
      end else if (sess_en_q) begin
        if (charge[ProdW-1:DataW] != '0) r.status = ST_OVERFLOW;
        else if (charge[DataW-1:0] > pool_q) r.status = ST_NO_CREDIT;
      end
      if (r.status == ST_OK) begin
        if (sess_en_q) pool_q = pool_q - charge[DataW-1:0];
        left_q[idx] = left_q[idx] - amt;
      end
      r.budget_left = left_q[idx];
      r.budget_used = limit_q[idx] - left_q[idx];
      if (!sess_en_q) r.units_affordable = left_q[idx];
      else if (c != '0) r.units_affordable = pool_q / c;
      else r.units_affordable = AllOnes;
    end
    r.credit_left = pool_q;
    r.credit_used = sess_credit_q - pool_q;
    return r;
  endfunction

  task automatic note_fail(input string what, input logic [DataW-1:0] got,
                           input logic [DataW-1:0] want);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      $display("%t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  task automatic check_field(input string what, input logic [DataW-1:0] got,
                             input logic [DataW-1:0] want);
    if (got !== want) note_fail(what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_proc
    meter_result_t want;
    if (!rst_ni) begin
      meter_reset();
      expected_q.delete();
      fail_cnt = 0;
      seen_cnt = 0;
      fail_count_o   <= 0;
      pending_o      <= 0;
      results_seen_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        apply_reg(reg_e'(paddr_i[AddrW-1:3]), pwdata_i);
      end
      if (result_mon.valid && result_mon.ready) begin
        seen_cnt++;
        if (expected_q.size() == 0) begin
          note_fail("unexpected result transfer", result_mon.credit_left, '0);
        end else begin
          want = expected_q.pop_front();
          check_field("status", DataW'(result_mon.status), DataW'(want.status));
          check_field("budget_left", result_mon.budget_left, want.budget_left);
          check_field("budget_used", result_mon.budget_used, want.budget_used);
          check_field("credit_left", result_mon.credit_left, want.credit_left);
          check_field("credit_used", result_mon.credit_used, want.credit_used);
          check_field("units_affordable", result_mon.units_affordable,
                      want.units_affordable);
        end
      end
      if (item_mon.valid && item_mon.ready) begin
        expected_q.push_back(meter_charge(mode_e'(item_mon.mode), item_mon.amount));
      end
      fail_count_o   <= fail_cnt;
      pending_o      <= expected_q.size();
      results_seen_o <= seen_cnt;
    end
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Top of the credit meter testbench: clock, reset, register programming, request and result traffic.
module tb_top;
  import tcm_pkg::*;

  // Extra wait after the final drain, before the verdict is given.
  localparam int unsigned DrainCycles = 100;
  // Length of the deliberate hold-off on the result side, which fills the block.
  localparam int unsigned HoldCycles  = 600;
  localparam int unsigned RandPhases  = 9;
  localparam int unsigned PhaseItems  = 140;
  // Generous ceiling on the run length, well above a correct run even with the longest
  // gaps on both sides stacked on every request.
  localparam int unsigned CycleLimit  = 3_000_000;

  logic             clk_i  = 1'b0;
  logic             rst_ni = 1'b0;

  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  tcm_item_if   item_bus ();
  tcm_result_if result_bus ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned cycle_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned settings_applied = 0;

  // Shared between the request process and the result process to steer idling.
  bit tx_eager  = 1'b0;
  bit rx_eager  = 1'b0;
  bit long_hold = 1'b0;

  // Copies of what has been programmed, used only to aim the amounts at the
  // interesting boundaries; the checker keeps its own view.
  logic [DataW-1:0] lim_sh  [3];
  logic [DataW-1:0] cost_sh [3];

  three_resource_credit_meter u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (result_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  tcm_meter_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_mon       (item_bus),
    .result_mon     (result_bus),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .pready_i       (pready),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_seen_o (results_seen)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycle_cnt, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [DataW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  function automatic logic [DataW-1:0] pick_budget();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return AllOnes;
      2, 3:    return DataW'($urandom_range(0, 5000));
      4:       return rand64();
      default: return rand64() >> $urandom_range(0, 63);
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_cost();
    case ($urandom_range(0, 7))
      0, 1:    return '0;
      2, 3:    return DataW'($urandom_range(1, 16));
      4:       return AllOnes;
      5:       return rand64();
      6:       return DataW'(1) << $urandom_range(16, 63);
      default: return rand64() >> $urandom_range(0, 63);
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_credit();
    case ($urandom_range(0, 5))
      0:       return '0;
      1, 2:    return AllOnes;
      3:       return DataW'($urandom_range(0, 100000));
      4:       return rand64();
      default: return rand64() >> $urandom_range(0, 63);
    endcase
  endfunction

  function automatic mode_e pick_mode();
    if ($urandom_range(0, 99) < 10) return MODE_NONE;
    return mode_e'($urandom_range(0, 2));
  endfunction

  // Amounts cluster around the budget limit and the multiply overflow point, so that
  // every status comes up regularly, with plenty of small successful charges between.
  function automatic logic [DataW-1:0] pick_amount(input mode_e m);
    int unsigned      k;
    int               idx;
    logic [DataW-1:0] c;
    k = $urandom_range(0, 99);
    if (m == MODE_NONE) return (k < 50) ? '0 : rand64();
    idx = int'(m);
    c   = cost_sh[idx];
    if (k < 8) return '0;
    if (k < 40) return DataW'($urandom_range(1, 64));
    if (k < 55) return DataW'($urandom_range(1, 1 << 20));
    if (k < 65) return (c != '0) ? (AllOnes / c) + DataW'($urandom_range(0, 1)) : rand64();
    if (k < 75) return rand64();
    if (k < 85) return lim_sh[idx] + DataW'($urandom_range(0, 1));
    return rand64() >> $urandom_range(0, 63);
  endfunction

  // One APB write: setup phase, access phase, then the bus is released.
  task automatic reg_write(input reg_e idx, input logic [DataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_DISK_LIMIT: lim_sh[0]  = val;
      REG_NET_LIMIT:  lim_sh[1]  = val;
      REG_COMP_LIMIT: lim_sh[2]  = val;
      REG_DISK_COST:  cost_sh[0] = val;
      REG_NET_COST:   cost_sh[1] = val;
      REG_COMP_COST:  cost_sh[2] = val;
      default: ;
    endcase
  endtask

  // Stops offering requests and waits until every predicted result has been transferred.
  task automatic wait_drained();
    item_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic program_all(input logic [DataW-1:0] dl, input logic [DataW-1:0] nl,
                             input logic [DataW-1:0] cl, input logic [DataW-1:0] dc,
                             input logic [DataW-1:0] nc, input logic [DataW-1:0] cc,
                             input logic [DataW-1:0] cred, input logic en);
    wait_drained();
    reg_write(REG_DISK_LIMIT, dl);
    reg_write(REG_NET_LIMIT, nl);
    reg_write(REG_COMP_LIMIT, cl);
    reg_write(REG_DISK_COST, dc);
    reg_write(REG_NET_COST, nc);
    reg_write(REG_COMP_COST, cc);
    reg_write(REG_SESS_CRED, cred);
    reg_write(REG_SESS_EN, DataW'(en));
    settings_applied++;
  endtask

  // Offers one request and returns at the edge where it is transferred. Valid is only
  // lowered when a gap is wanted, so back-to-back requests never toggle it in one step.
  task automatic send_item(input mode_e m, input logic [DataW-1:0] amt);
    int unsigned gap;
    gap = tx_eager ? 0 : pick_gap();
    if (gap != 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_bus.valid  <= 1'b1;
    item_bus.mode   <= m;
    item_bus.amount <= amt;
    do @(posedge clk_i); while (!item_bus.ready);
    items_sent++;
  endtask

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin : rx_proc
    int unsigned gap;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        result_bus.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        long_hold = 1'b0;
      end else begin
        gap = rx_eager ? 0 : pick_gap();
        if (gap == 0) begin
          result_bus.ready <= 1'b1;
        end else begin
          result_bus.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  initial begin : stim_proc
    mode_e m;
    for (int i = 0; i < 3; i++) begin
      lim_sh[i]  = AllOnes;
      cost_sh[i] = '0;
    end
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    item_bus.valid  <= 1'b0;
    item_bus.mode   <= MODE_DISK;
    item_bus.amount <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: no session, unlimited budgets. A zero amount is a pure query, the
    // unused resource code reports nothing, and a full-range charge empties the budget.
    send_item(MODE_DISK, '0);
    send_item(MODE_NONE, DataW'(5));
    send_item(MODE_DISK, AllOnes);
    send_item(MODE_DISK, DataW'(1));

    // Small budgets inside a session: a successful charge, a budget overrun, a
    // product that overflows, a pool too small, and a free resource.
    program_all(DataW'(100), DataW'(1000), AllOnes, DataW'(3), '0, AllOnes,
                DataW'(1000), 1'b1);
    send_item(MODE_DISK, DataW'(10));
    send_item(MODE_DISK, DataW'(91));
    send_item(MODE_COMP, DataW'(2));
    send_item(MODE_COMP, DataW'(1));
    send_item(MODE_NET, DataW'(500));
    send_item(MODE_DISK, DataW'(90));
    send_item(MODE_NONE, AllOnes);
    send_item(MODE_COMP, '0);

    // A full pool and the exact edge of the 64-bit product.
    program_all(AllOnes, '0, AllOnes, DataW'(1), AllOnes, DataW'(2), AllOnes, 1'b1);
    send_item(MODE_COMP, AllOnes >> 1);
    send_item(MODE_COMP, ~(AllOnes >> 1));
    send_item(MODE_DISK, AllOnes);
    send_item(MODE_DISK, DataW'(1));
    send_item(MODE_NET, DataW'(1));
    send_item(MODE_NET, '0);

    // Session switched off again, with the pool left as it was.
    wait_drained();
    reg_write(REG_SESS_EN, '0);
    send_item(MODE_NET, '0);
    send_item(MODE_DISK, DataW'(5));
    send_item(MODE_COMP, AllOnes);
    send_item(MODE_NONE, '0);

    for (int phase = 0; phase < RandPhases; phase++) begin
      program_all(pick_budget(), pick_budget(), pick_budget(), pick_cost(), pick_cost(),
                  pick_cost(), pick_credit(), ($urandom_range(0, 99) < 70));
      // One phase fills the block against a stalled receiver; a later phase runs flat
      // out on both sides.
      tx_eager = (phase == 3) || (phase == 1);
      rx_eager = (phase == 3);
      for (int n = 0; n < PhaseItems; n++) begin
        if (phase == 1 && n == 20) long_hold = 1'b1;
        if (phase != 1 && $urandom_range(0, 99) == 0) wait_drained();
        m = pick_mode();
        send_item(m, pick_amount(m));
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Summary: %0d requests over %0d register settings, %0d results compared.",
             items_sent, settings_applied, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding.", fail_count, pending);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // The block always answers with pready high; nothing here reads back prdata.
  logic unused_rd;
  assign unused_rd = ^{prdata, pready};

endmodule
